>>> sv/rcde_pkg.sv
// rcde_pkg: shared constants and the digit-to-ASCII function of the radix
// conversion digit emitter.
// No dependencies.
package rcde_pkg;

	localparam int DEF_VALUE_BITS = 31;
	localparam int DEF_MAX_DIGITS = 31;

	localparam int RADIX_BITS  = 5;
	localparam int DIGIT_BITS  = 4;
	localparam int CHAR_BITS   = 7;
	localparam int OUT_TDATA_W = ((DIGIT_BITS + CHAR_BITS + 7) / 8) * 8;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

	localparam logic [DIGIT_BITS-1:0] LETTER_BASE = 4'd10;
	localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_BITS-1:0]  CHAR_A      = 7'h41;

	function automatic logic [CHAR_BITS-1:0] ascii_of(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] d_w;
		d_w = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
		if (d < LETTER_BASE)
			return CHAR_ZERO + d_w;
		return CHAR_A + d_w - {{(CHAR_BITS-DIGIT_BITS){1'b0}}, LETTER_BASE};
	endfunction

endpackage

>>> sv/rcde_ram.sv
// rcde_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module rcde_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/rcde_div.sv
// rcde_div: restoring divider, one quotient bit per cycle, for a wide
// dividend over a narrow radix. Depends on rcde_pkg.
module rcde_div #(
	parameter int VALUE_BITS = rcde_pkg::DEF_VALUE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [VALUE_BITS-1:0]           dividend,
	input  logic [rcde_pkg::RADIX_BITS-1:0] divisor,
	output logic                            done,
	output logic [VALUE_BITS-1:0]           quotient,
	output logic [rcde_pkg::DIGIT_BITS-1:0] remainder
);
	import rcde_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_BITS-1:0] rem_q;
	logic [RADIX_BITS-1:0] dvs_q;

	logic [RADIX_BITS:0]   partial;
	logic [RADIX_BITS:0]   diff;
	logic                  ge;

	assign partial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge      = partial >= {1'b0, dvs_q};
	assign diff    = partial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(VALUE_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[RADIX_BITS-1:0] : partial[RADIX_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DIGIT_BITS-1:0];

endmodule

>>> sv/radix_conversion_digit_emitter_unit.sv
// radix_conversion_digit_emitter_unit: converts an integer to digits in
// radix 2..16, most significant first. Depends on rcde_pkg, rcde_div, rcde_ram.
//
// channel  dir  tdata (low bit up)                       tlast
// s_*      in   value[VALUE_BITS], radix[5], zero pad    -
// m_*      out  digit_value[4], digit_char[7], zero pad  last digit
//
// Each digit comes from the bit-serial divider and is then popped from the
// digit RAM through a read state and a load state (ST_RD, ST_LOAD).
// Items with a bad radix or a zero value are taken with no output.
// A stalled output holds the pop sequencer; the next item is taken while
// the last digit still waits. Reset clears control state only.
module radix_conversion_digit_emitter_unit #(
	parameter int VALUE_BITS = rcde_pkg::DEF_VALUE_BITS,
	parameter int MAX_DIGITS = rcde_pkg::DEF_MAX_DIGITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// value, radix, zero pad
	input  logic [((VALUE_BITS+rcde_pkg::RADIX_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// digit_value, digit_char, zero pad
	output logic [rcde_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic m_tlast
);
	import rcde_pkg::*;

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0]            state_q;
	logic [1:0]            state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_d;
	logic [RADIX_BITS-1:0] radix_q;

	logic                  m_valid_q;
	logic [DIGIT_BITS-1:0] dig_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] in_value;
	logic [RADIX_BITS-1:0] in_radix;
	logic                  radix_ok;

	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [RADIX_BITS-1:0] div_divisor;
	logic [VALUE_BITS-1:0] div_quo;
	logic [DIGIT_BITS-1:0] div_rem;

	logic                  ram_we;
	logic                  ram_re;
	logic [CNT_W-1:0]      cnt_m1;
	logic [DIGIT_BITS-1:0] ram_rdata;
	logic                  out_free;
	logic                  more;

	assign in_value = s_tdata[VALUE_BITS-1:0];
	assign in_radix = s_tdata[VALUE_BITS +: RADIX_BITS];
	assign radix_ok = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign cnt_m1   = cnt_q - 1'b1;
	assign more     = (div_quo != '0) && (cnt_q + 1'b1 < CNT_W'(MAX_DIGITS));

	assign div_dividend = (state_q == ST_IDLE) ? in_value : div_quo;
	assign div_divisor  = (state_q == ST_IDLE) ? in_radix : radix_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		div_start = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (s_tvalid && radix_ok && in_value != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ram_we = 1'b1;
					cnt_d  = cnt_q + 1'b1;
					if (more) begin
						div_start = 1'b1;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				if (out_free) begin
					ram_re  = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cnt_d   = cnt_m1;
				state_d = (cnt_m1 == '0) ? ST_IDLE : ST_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_LOAD)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid)
			radix_q <= in_radix;
		if (state_q == ST_LOAD) begin
			dig_q  <= ram_rdata;
			last_q <= (cnt_m1 == '0);
		end
	end

	rcde_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	rcde_ram #(
		.WIDTH(DIGIT_BITS),
		.DEPTH(MAX_DIGITS)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(div_rem),
		.re   (ram_re),
		.raddr(cnt_m1[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_TDATA_W-DIGIT_BITS-CHAR_BITS){1'b0}}, ascii_of(dig_q), dig_q};

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> !m_valid_q)
		else $error("digit loaded over an untaken item");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond stack depth");

	a_push_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_DIV) && div_done)
		else $error("stack write without divider result");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) && (cnt_q == CNT_W'(1)) |=> (state_q == ST_IDLE) && m_tlast)
		else $error("final digit did not end the run");

endmodule
